FILE: hdl/iee_pkg.sv
// Shared types and constants for the infix expression evaluator.
package iee_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int ACC_WIDTH   = 64;
	localparam int OPND_W      = 30;
	localparam int CMD_W       = 3;
	localparam int STATUS_W    = 2;
	localparam int RES_W       = 64;
	localparam int IN_TDATA_W  = 32;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(ACC_WIDTH);

	typedef logic [ACC_WIDTH-1:0] acc_t;

	localparam acc_t ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
	localparam acc_t ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

	typedef enum logic [CMD_W-1:0] {
		CMD_OPERAND = 3'd0,
		CMD_PLUS    = 3'd1,
		CMD_MINUS   = 3'd2,
		CMD_MUL     = 3'd3,
		CMD_DIV     = 3'd4,
		CMD_EQUALS  = 3'd5
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_DIV_ZERO  = 2'd1,
		ST_MALFORMED = 2'd2,
		ST_OVERFLOW  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		PEND_ADD = 2'd0,
		PEND_MUL = 2'd1,
		PEND_DIV = 2'd2
	} pend_t;

	typedef enum logic [1:0] {
		BK_IDLE = 2'd0,
		BK_MUL  = 2'd1,
		BK_DIV  = 2'd2
	} back_state_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [OPND_W-1:0] value;
	} tok_t;

endpackage

FILE: hdl/infix_expression_evaluator.sv
// Two-level precedence infix evaluator for calculator tokens, top level.
// Tokens (command in tuser, operand in tdata) are registered on intake and pass through a
// four-entry queue to the evaluation engine, which handles most tokens directly. An operand
// after multiply runs a shift-add multiplier one operand bit per cycle; an operand after
// divide runs a restoring divider one quotient bit per cycle. Intake keeps taking requests
// while the engine iterates, until the queue fills. Each equals produces one result request:
// the signed fixed-point value (16 fraction bits) in tdata and the status (ok, division by
// zero, malformed, overflow saturated) in tuser, held in an output register so the engine
// keeps taking other tokens while a result waits.
module infix_expression_evaluator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [iee_pkg::IN_TDATA_W-1:0] s_axis_tdata,  // [29:0] operand_value, [31:30] zero
	input  logic [iee_pkg::CMD_W-1:0]      s_axis_tuser,  // [2:0] command
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [iee_pkg::RES_W-1:0]      m_axis_tdata,  // [63:0] result_value
	output logic [iee_pkg::STATUS_W-1:0]   m_axis_tuser   // [1:0] status
);
	import iee_pkg::*;

	logic front_valid;
	logic front_ready;
	tok_t front_tok;
	logic q_valid;
	logic q_ready;
	tok_t q_tok;

	iee_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.tok_valid     (front_valid),
		.tok_ready     (front_ready),
		.tok           (front_tok)
	);

	iee_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_tok   (front_tok),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_tok    (q_tok)
	);

	iee_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.tok_valid     (q_valid),
		.tok_ready     (q_ready),
		.tok           (q_tok),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

FILE: hdl/iee_front.sv
// Token intake: accepts requests, drops unused command codes, feeds the queue.
module iee_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [iee_pkg::IN_TDATA_W-1:0] s_axis_tdata,  // [29:0] operand_value, [31:30] zero
	input  logic [iee_pkg::CMD_W-1:0]      s_axis_tuser,  // [2:0] command
	output logic                           tok_valid,
	input  logic                           tok_ready,
	output iee_pkg::tok_t                  tok
);
	import iee_pkg::*;

	logic valid_s1;
	tok_t tok_s1;
	logic accept;
	logic keep;
	cmd_t cmd;

	assign cmd           = cmd_t'(s_axis_tuser);
	assign s_axis_tready = !valid_s1 || tok_ready;
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_comb begin
		case (cmd)
			CMD_OPERAND, CMD_PLUS, CMD_MINUS, CMD_MUL, CMD_DIV, CMD_EQUALS: keep = 1'b1;
			default: keep = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= keep;
		end else if (tok_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && keep) begin
			tok_s1.cmd   <= cmd;
			tok_s1.value <= s_axis_tdata[OPND_W-1:0];
		end
	end

	assign tok_valid = valid_s1;
	assign tok       = tok_s1;

endmodule

FILE: hdl/iee_queue.sv
// Short token queue between intake and execution.
module iee_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  iee_pkg::tok_t push_tok,
	output logic          pop_valid,
	input  logic          pop_ready,
	output iee_pkg::tok_t pop_tok
);
	import iee_pkg::*;

	tok_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = count_q != (QPTR_W+1)'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_tok    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_tok;
	end

endmodule

FILE: hdl/iee_back.sv
// Evaluation engine: two-level precedence state, iterative multiply and divide, result register.
module iee_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         tok_valid,
	output logic                         tok_ready,
	input  iee_pkg::tok_t                tok,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [iee_pkg::RES_W-1:0]    m_axis_tdata,  // [63:0] result_value
	output logic [iee_pkg::STATUS_W-1:0] m_axis_tuser   // [1:0] status
);
	import iee_pkg::*;

	localparam int LOAD_W = OPND_W + FRAC_BITS + ACC_WIDTH;

	typedef struct packed {
		logic ovf;
		acc_t value;
	} sat_t;

	function automatic sat_t sat_add(acc_t a, acc_t b, logic sub);
		logic [ACC_WIDTH:0] ax;
		logic [ACC_WIDTH:0] bx;
		logic [ACC_WIDTH:0] s;
		sat_t               res;
		ax        = {a[ACC_WIDTH-1], a};
		bx        = {b[ACC_WIDTH-1], b};
		s         = sub ? ax - bx : ax + bx;
		res.ovf   = s[ACC_WIDTH] ^ s[ACC_WIDTH-1];
		res.value = res.ovf ? (s[ACC_WIDTH] ? ACC_MIN : ACC_MAX) : s[ACC_WIDTH-1:0];
		return res;
	endfunction

	back_state_t       state_q, state_d;
	acc_t              sum_q, sum_d;
	acc_t              term_q, term_d;
	logic              neg_q, neg_d;
	pend_t             pend_q, pend_d;
	logic              expect_q, expect_d;
	logic              locked_q, locked_d;
	acc_t              lock_val_q, lock_val_d;
	status_t           status_q, status_d;
	acc_t              acc_q, acc_d;
	logic              ovf_q, ovf_d;
	logic [OPND_W-1:0] rem_q, rem_d;
	logic [OPND_W-1:0] opnd_q, opnd_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic              out_valid_q, out_valid_d;
	logic [RES_W-1:0]  out_value_q, out_value_d;
	status_t           out_status_q, out_status_d;

	logic               pop;
	sat_t               add_r;
	logic [LOAD_W-1:0]  load_wide;
	logic               load_ovf;
	logic [ACC_WIDTH:0] mul_sum;
	logic               mul_ovf;
	logic               mul_last;
	logic [OPND_W:0]    div_r2;
	logic [OPND_W:0]    div_diff;
	logic               div_ge;
	acc_t               div_quo;
	logic               div_last;

	assign pop = tok_valid && (state_q == BK_IDLE)
		&& (tok.cmd != CMD_EQUALS || !out_valid_q || m_axis_tready);
	assign tok_ready = pop;

	assign add_r     = sat_add(sum_q, term_q, neg_q);
	assign load_wide = LOAD_W'(tok.value) << FRAC_BITS;
	assign load_ovf  = load_wide > LOAD_W'(ACC_MAX);

	assign mul_sum  = {acc_q, 1'b0} + (opnd_q[OPND_W-1] ? {1'b0, term_q} : '0);
	assign mul_ovf  = ovf_q || (mul_sum > {1'b0, ACC_MAX});
	assign mul_last = cnt_q == CNT_W'(OPND_W - 1);

	assign div_r2   = {rem_q, acc_q[ACC_WIDTH-1]};
	assign div_diff = div_r2 - {1'b0, opnd_q};
	assign div_ge   = div_r2 >= {1'b0, opnd_q};
	assign div_quo  = {acc_q[ACC_WIDTH-2:0], div_ge};
	assign div_last = cnt_q == CNT_W'(ACC_WIDTH - 1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (pop && !locked_q && tok.cmd == CMD_OPERAND && expect_q) begin
					if (pend_q == PEND_MUL && tok.value != '0 && term_q != '0) state_d = BK_MUL;
					else if (pend_q == PEND_DIV && tok.value != '0) state_d = BK_DIV;
				end
			end
			BK_MUL: if (mul_last) state_d = BK_IDLE;
			BK_DIV: if (div_last) state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		sum_d        = sum_q;
		term_d       = term_q;
		neg_d        = neg_q;
		pend_d       = pend_q;
		expect_d     = expect_q;
		locked_d     = locked_q;
		lock_val_d   = lock_val_q;
		status_d     = status_q;
		acc_d        = acc_q;
		ovf_d        = ovf_q;
		rem_d        = rem_q;
		opnd_d       = opnd_q;
		cnt_d        = cnt_q;
		out_valid_d  = out_valid_q && !m_axis_tready;
		out_value_d  = out_value_q;
		out_status_d = out_status_q;
		case (state_q)
			BK_IDLE: begin
				if (pop && tok.cmd == CMD_EQUALS) begin
					out_valid_d = 1'b1;
					if (locked_q) begin
						out_value_d  = RES_W'($signed(lock_val_q));
						out_status_d = status_q;
					end else begin
						out_value_d  = RES_W'($signed(add_r.value));
						out_status_d = add_r.ovf ? ST_OVERFLOW : status_q;
					end
					sum_d      = '0;
					term_d     = '0;
					neg_d      = 1'b0;
					pend_d     = PEND_ADD;
					expect_d   = 1'b1;
					locked_d   = 1'b0;
					lock_val_d = '0;
					status_d   = ST_OK;
				end else if (pop && !locked_q) begin
					case (tok.cmd)
						CMD_OPERAND: begin
							if (expect_q) begin
								case (pend_q)
									PEND_MUL: begin
										acc_d  = '0;
										ovf_d  = 1'b0;
										cnt_d  = '0;
										opnd_d = tok.value;
										if (tok.value == '0 || term_q == '0) begin
											term_d   = '0;
											expect_d = 1'b0;
										end
									end
									PEND_DIV: begin
										if (tok.value == '0) begin
											locked_d   = 1'b1;
											lock_val_d = term_q;
											status_d   = ST_DIV_ZERO;
										end else begin
											acc_d  = term_q;
											rem_d  = '0;
											cnt_d  = '0;
											opnd_d = tok.value;
										end
									end
									default: begin
										term_d   = load_ovf ? ACC_MAX : load_wide[ACC_WIDTH-1:0];
										if (load_ovf) status_d = ST_OVERFLOW;
										expect_d = 1'b0;
									end
								endcase
							end
						end
						CMD_PLUS, CMD_MINUS: begin
							if (expect_q) begin
								locked_d   = 1'b1;
								lock_val_d = '0;
								status_d   = ST_MALFORMED;
							end else begin
								sum_d    = add_r.value;
								if (add_r.ovf) status_d = ST_OVERFLOW;
								term_d   = '0;
								neg_d    = tok.cmd == CMD_MINUS;
								pend_d   = PEND_ADD;
								expect_d = 1'b1;
							end
						end
						CMD_MUL, CMD_DIV: begin
							if (expect_q) begin
								locked_d   = 1'b1;
								lock_val_d = '0;
								status_d   = ST_MALFORMED;
							end else begin
								pend_d   = (tok.cmd == CMD_MUL) ? PEND_MUL : PEND_DIV;
								expect_d = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
			BK_MUL: begin
				acc_d  = mul_sum[ACC_WIDTH-1:0];
				ovf_d  = mul_ovf;
				opnd_d = opnd_q << 1;
				cnt_d  = cnt_q + 1'b1;
				if (mul_last) begin
					term_d   = mul_ovf ? ACC_MAX : mul_sum[ACC_WIDTH-1:0];
					if (mul_ovf) status_d = ST_OVERFLOW;
					expect_d = 1'b0;
				end
			end
			BK_DIV: begin
				acc_d = div_quo;
				rem_d = div_ge ? div_diff[OPND_W-1:0] : div_r2[OPND_W-1:0];
				cnt_d = cnt_q + 1'b1;
				if (div_last) begin
					term_d   = div_quo;
					expect_d = 1'b0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			sum_q       <= '0;
			term_q      <= '0;
			neg_q       <= 1'b0;
			pend_q      <= PEND_ADD;
			expect_q    <= 1'b1;
			locked_q    <= 1'b0;
			lock_val_q  <= '0;
			status_q    <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			sum_q       <= sum_d;
			term_q      <= term_d;
			neg_q       <= neg_d;
			pend_q      <= pend_d;
			expect_q    <= expect_d;
			locked_q    <= locked_d;
			lock_val_q  <= lock_val_d;
			status_q    <= status_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		acc_q        <= acc_d;
		ovf_q        <= ovf_d;
		rem_q        <= rem_d;
		opnd_q       <= opnd_d;
		cnt_q        <= cnt_d;
		out_value_q  <= out_value_d;
		out_status_q <= out_status_d;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_value_q;
	assign m_axis_tuser  = out_status_q;

	// no token is taken while an operand is being folded in
	a_busy_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != BK_IDLE) |-> !pop)
		else $error("token popped while multiply/divide busy");

	a_busy_not_locked: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != BK_IDLE) |-> (!locked_q && expect_q))
		else $error("iteration running in locked or operator-expecting state");

	a_term_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		!term_q[ACC_WIDTH-1])
		else $error("product term went negative");

	a_equals_result: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && tok.cmd == CMD_EQUALS) |=> out_valid_q)
		else $error("equals did not load a result");

endmodule

FILE: tb/sv/tb.sv
// Testbench for infix_expression_evaluator: token streams, predicted results, checks.
module tb;
	import iee_pkg::*;

	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int RANDOM_TOKENS = 1950;
	localparam int DRAIN_CYCLES = 400;
	localparam logic [OPND_W-1:0] OPND_MAX = 30'd999_999_999;
	localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

	typedef struct {
		acc_t    value;
		status_t status;
	} answer_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata;
	logic [CMD_W-1:0]      s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [RES_W-1:0]      m_axis_tdata;
	logic [STATUS_W-1:0]   m_axis_tuser;

	// calculator state mirror
	acc_t    sum_acc;
	acc_t    term_acc;
	logic    term_neg;
	pend_t   pend;
	logic    want_operand;
	logic    err_locked;
	acc_t    err_value;
	status_t status_hold;

	answer_t expected_answers[$];
	int      token_count;
	int      mismatch_count;
	int      cycle_count;
	bit      gap_free;

	infix_expression_evaluator i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void clear_calc();
		sum_acc      = '0;
		term_acc     = '0;
		term_neg     = 1'b0;
		pend         = PEND_ADD;
		want_operand = 1'b1;
		err_locked   = 1'b0;
		err_value    = '0;
		status_hold  = ST_OK;
	endfunction

	function automatic void lock_error(acc_t value, status_t st);
		err_locked  = 1'b1;
		err_value   = value;
		status_hold = st;
	endfunction

	function automatic acc_t add_sat(acc_t a, acc_t b, logic sub);
		logic [ACC_WIDTH:0] s;
		s = sub ? {a[ACC_WIDTH-1], a} - {b[ACC_WIDTH-1], b}
			: {a[ACC_WIDTH-1], a} + {b[ACC_WIDTH-1], b};
		if (s[ACC_WIDTH] != s[ACC_WIDTH-1]) begin
			if (!err_locked)
				status_hold = ST_OVERFLOW;
			return s[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
		end
		return s[ACC_WIDTH-1:0];
	endfunction

	function automatic acc_t mul_sat(acc_t t, logic [OPND_W-1:0] v);
		logic                      neg;
		acc_t                      m;
		logic [ACC_WIDTH+OPND_W-1:0] p;
		logic [ACC_WIDTH+OPND_W-1:0] lim;
		neg = t[ACC_WIDTH-1];
		m = neg ? -t : t;
		if (v == '0 || m == '0)
			return '0;
		p = m * v;
		lim = neg ? {{OPND_W{1'b0}}, ACC_MIN} : {{OPND_W{1'b0}}, ACC_MAX};
		if (p > lim) begin
			if (!err_locked)
				status_hold = ST_OVERFLOW;
			return neg ? ACC_MIN : ACC_MAX;
		end
		return neg ? -p[ACC_WIDTH-1:0] : p[ACC_WIDTH-1:0];
	endfunction

	function automatic acc_t div_trunc(acc_t t, logic [OPND_W-1:0] v);
		logic neg;
		acc_t m;
		acc_t q;
		neg = t[ACC_WIDTH-1];
		m = neg ? -t : t;
		q = m / {{(ACC_WIDTH-OPND_W){1'b0}}, v};
		return neg ? -q : q;
	endfunction

	task automatic evaluate_token(logic [CMD_W-1:0] c, logic [OPND_W-1:0] v);
		answer_t a;
		if (c == CMD_EQUALS) begin
			a.value = err_locked ? err_value : add_sat(sum_acc, term_acc, term_neg);
			a.status = status_hold;
			expected_answers = {expected_answers, a};
			clear_calc();
		end else if (c > CMD_EQUALS || err_locked) begin
			// ignored
		end else if (c == CMD_OPERAND) begin
			if (want_operand) begin
				if (pend == PEND_DIV && v == '0) begin
					lock_error(term_acc, ST_DIV_ZERO);
				end else begin
					case (pend)
						PEND_MUL: term_acc = mul_sat(term_acc, v);
						PEND_DIV: term_acc = div_trunc(term_acc, v);
						default:  term_acc = acc_t'(v) << FRAC_BITS;
					endcase
					want_operand = 1'b0;
				end
			end
		end else if (want_operand) begin
			lock_error('0, ST_MALFORMED);
		end else if (c == CMD_PLUS || c == CMD_MINUS) begin
			sum_acc = add_sat(sum_acc, term_acc, term_neg);
			term_acc = '0;
			term_neg = (c == CMD_MINUS);
			pend = PEND_ADD;
			want_operand = 1'b1;
		end else begin
			pend = (c == CMD_MUL) ? PEND_MUL : PEND_DIV;
			want_operand = 1'b1;
		end
	endtask

	// input requests feed the mirror, output requests are checked against it
	always @(posedge clk) begin
		answer_t a;
		if (!arst_n) begin
			clear_calc();
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				evaluate_token(s_axis_tuser, s_axis_tdata[OPND_W-1:0]);
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_answers.size() == 0) begin
					$error("unexpected result request: value %0d status %0d",
						$signed(m_axis_tdata), m_axis_tuser);
					mismatch_count++;
				end else begin
					a = expected_answers.pop_front();
					if (m_axis_tdata !== a.value) begin
						$error("result_value expected %0d actual %0d",
							$signed(a.value), $signed(m_axis_tdata));
						mismatch_count++;
					end
					if (m_axis_tuser !== a.status) begin
						$error("status expected %0d actual %0d", a.status, m_axis_tuser);
						mismatch_count++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		if (gap_free)
			return 0;
		r = $urandom_range(99, 0);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(3, 1);
		if (r < 97)
			return $urandom_range(20, 4);
		return $urandom_range(200, 30);
	endfunction

	// result side back-pressure
	initial begin
		int g;
		forever begin
			m_axis_tready <= 1'b1;
			repeat ($urandom_range(8, 1)) @(posedge clk);
			g = pick_gap();
			if (g > 0) begin
				m_axis_tready <= 1'b0;
				repeat (g) @(posedge clk);
			end
		end
	end

	task automatic send_token(logic [CMD_W-1:0] c, logic [OPND_W-1:0] v);
		int g;
		g = pick_gap();
		if (g > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= c;
		s_axis_tdata  <= {{(IN_TDATA_W-OPND_W){1'b0}}, v};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		token_count++;
	endtask

	function automatic logic [OPND_W-1:0] rand_operand();
		int r;
		r = $urandom_range(9, 0);
		if (r < 4)
			return OPND_W'($urandom_range(9, 0));
		if (r < 7)
			return OPND_W'($urandom_range(65535, 0));
		if (r < 9)
			return OPND_W'($urandom_range(OPND_MAX, 0));
		return $urandom_range(1, 0) ? OPND_MAX : '0;
	endfunction

	function automatic logic [CMD_W-1:0] rand_operator();
		case ($urandom_range(3, 0))
			0:       return CMD_PLUS;
			1:       return CMD_MINUS;
			2:       return CMD_MUL;
			default: return CMD_DIV;
		endcase
	endfunction

	task automatic test_arithmetic();
		send_token(CMD_EQUALS, '0);
		send_token(CMD_OPERAND, 30'd7);
		send_token(CMD_MUL, '0);
		send_token(CMD_OPERAND, 30'd3);
		send_token(CMD_MINUS, '0);
		send_token(CMD_OPERAND, 30'd10);
		send_token(CMD_DIV, '0);
		send_token(CMD_OPERAND, 30'd4);
		send_token(CMD_EQUALS, '0);
	endtask

	task automatic test_errors();
		send_token(CMD_OPERAND, 30'd5);
		send_token(CMD_DIV, '0);
		send_token(CMD_OPERAND, '0);
		send_token(CMD_EQUALS, '0);
		send_token(CMD_MUL, '0);
		send_token(CMD_EQUALS, '0);
		// ignored operand, spare commands, trailing operator
		send_token(CMD_OPERAND, 30'd3);
		send_token(CMD_OPERAND, 30'd3);
		send_token(CMD_SPARE_6, OPND_MAX);
		send_token(CMD_SPARE_7, OPND_MAX);
		send_token(CMD_MINUS, '0);
		send_token(CMD_EQUALS, '0);
	endtask

	task automatic test_overflow();
		send_token(CMD_OPERAND, OPND_MAX);
		send_token(CMD_MUL, '0);
		send_token(CMD_OPERAND, OPND_MAX);
		send_token(CMD_MUL, '0);
		send_token(CMD_OPERAND, OPND_MAX);
		send_token(CMD_EQUALS, '0);
	endtask

	task automatic test_random();
		int stop_at;
		int n;
		stop_at = token_count + RANDOM_TOKENS;
		while (token_count < stop_at) begin
			if ($urandom_range(19, 0) == 0)
				gap_free = ($urandom_range(3, 0) == 0);
			if ($urandom_range(99, 0) < 15) begin
				// noise and broken sequences
				repeat ($urandom_range(6, 1))
					send_token(CMD_W'($urandom_range(7, 0)),
						OPND_W'($urandom_range(OPND_MAX, 0)));
				if ($urandom_range(1, 0))
					send_token(CMD_EQUALS, OPND_W'($urandom_range(OPND_MAX, 0)));
			end else begin
				n = ($urandom_range(9, 0) == 0) ? $urandom_range(12, 6) : $urandom_range(4, 1);
				send_token(CMD_OPERAND, rand_operand());
				repeat (n - 1) begin
					send_token(rand_operator(), OPND_W'($urandom_range(OPND_MAX, 0)));
					send_token(CMD_OPERAND, rand_operand());
				end
				if ($urandom_range(9, 0) == 0)
					send_token(rand_operator(), OPND_W'($urandom_range(OPND_MAX, 0)));
				send_token(CMD_EQUALS, OPND_W'($urandom_range(OPND_MAX, 0)));
			end
		end
		gap_free = 1'b0;
	endtask

	initial begin
		arst_n         <= 1'b0;
		s_axis_tvalid  <= 1'b0;
		s_axis_tdata   <= '0;
		s_axis_tuser   <= CMD_OPERAND;
		token_count    = 0;
		mismatch_count = 0;
		cycle_count    = 0;
		gap_free       = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_arithmetic();
		test_errors();
		test_overflow();
		test_random();
		s_axis_tvalid <= 1'b0;
		while (expected_answers.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_answers.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
